// File: rtl/nnsa_pkg.sv
`default_nettype none

package nnsa_pkg;

  localparam int COORD_W     = 12;
  localparam int REG_W       = 13;
  localparam int INDEX_W     = 24;
  localparam int MAX_DIM_DEF = 4096;
  localparam int REG_LIMIT   = 8191;
  localparam int CFG_IDX_W   = 4;
  localparam int S_DATA_W    = 2 * COORD_W;
  localparam int M_DATA_W    = 2 * COORD_W + 2 * INDEX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 4'd0,
    REG_SOURCE_HEIGHT = 4'd1,
    REG_TARGET_WIDTH  = 4'd2,
    REG_TARGET_HEIGHT = 4'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/nnsa_front.sv
`default_nettype none

module nnsa_front #(
  parameter int DW = 13,
  parameter int NW = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         up_valid,
  output      logic                         up_ready,
  input  wire logic [nnsa_pkg::COORD_W-1:0] col_in,
  input  wire logic [nnsa_pkg::COORD_W-1:0] row_in,
  input  wire logic [DW-1:0]                sw,
  input  wire logic [DW-1:0]                sh,
  input  wire logic [DW-1:0]                tw,
  input  wire logic [DW-1:0]                th,
  output      logic                         dn_valid,
  input  wire logic                         dn_ready,
  output      logic [NW-1:0]                rx,
  output      logic [NW-1:0]                ry,
  output      logic [nnsa_pkg::COORD_W-1:0] col,
  output      logic [nnsa_pkg::COORD_W-1:0] row,
  output      logic                         inr
);

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rx  <= NW'(col_in) * NW'(sw);
      ry  <= NW'(row_in) * NW'(sh);
      col <= col_in;
      row <= row_in;
      inr <= (NW'(col_in) < NW'(tw)) && (NW'(row_in) < NW'(th));
    end
  end

endmodule

`default_nettype wire

// File: rtl/nnsa_cell.sv
`default_nettype none

// one quotient bit (weight 2**K) for both axes
module nnsa_cell #(
  parameter int DW = 13,
  parameter int NW = 25,
  parameter int K  = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         up_valid,
  output      logic                         up_ready,
  input  wire logic [DW-1:0]                tw,
  input  wire logic [DW-1:0]                th,
  input  wire logic [NW-1:0]                rx_in,
  input  wire logic [NW-1:0]                ry_in,
  input  wire logic [DW-1:0]                qx_in,
  input  wire logic [DW-1:0]                qy_in,
  input  wire logic [nnsa_pkg::COORD_W-1:0] col_in,
  input  wire logic [nnsa_pkg::COORD_W-1:0] row_in,
  input  wire logic                         inr_in,
  output      logic                         dn_valid,
  input  wire logic                         dn_ready,
  output      logic [NW-1:0]                rx,
  output      logic [NW-1:0]                ry,
  output      logic [DW-1:0]                qx,
  output      logic [DW-1:0]                qy,
  output      logic [nnsa_pkg::COORD_W-1:0] col,
  output      logic [nnsa_pkg::COORD_W-1:0] row,
  output      logic                         inr
);

  localparam int XW = NW + DW;

  logic [XW-1:0] dx, dy, rxe, rye;
  logic          gex, gey;
  logic [NW-1:0] rx_next, ry_next;
  logic [DW-1:0] qx_next, qy_next;

  assign dx  = XW'(tw) << K;
  assign dy  = XW'(th) << K;
  assign rxe = XW'(rx_in);
  assign rye = XW'(ry_in);
  assign gex = rxe >= dx;
  assign gey = rye >= dy;

  assign rx_next = gex ? NW'(rxe - dx) : rx_in;
  assign ry_next = gey ? NW'(rye - dy) : ry_in;
  assign qx_next = qx_in | (DW'(gex) << K);
  assign qy_next = qy_in | (DW'(gey) << K);

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rx  <= rx_next;
      ry  <= ry_next;
      qx  <= qx_next;
      qy  <= qy_next;
      col <= col_in;
      row <= row_in;
      inr <= inr_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/nnsa_out.sv
`default_nettype none

module nnsa_out #(
  parameter int DW = 13
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         up_valid,
  output      logic                         up_ready,
  input  wire logic [DW-1:0]                qx,
  input  wire logic [DW-1:0]                qy,
  input  wire logic [nnsa_pkg::COORD_W-1:0] col,
  input  wire logic [nnsa_pkg::COORD_W-1:0] row,
  input  wire logic                         inr,
  input  wire logic [DW-1:0]                sw,
  input  wire logic [DW-1:0]                tw,
  output      logic                         dn_valid,
  input  wire logic                         dn_ready,
  output      logic [nnsa_pkg::COORD_W-1:0] src_col,
  output      logic [nnsa_pkg::COORD_W-1:0] src_row,
  output      logic [nnsa_pkg::INDEX_W-1:0] src_index,
  output      logic [nnsa_pkg::INDEX_W-1:0] dst_index,
  output      logic                         in_range
);

  localparam int SW = nnsa_pkg::INDEX_W + 2 * DW;
  localparam int CW = nnsa_pkg::COORD_W;
  localparam int IW = nnsa_pkg::INDEX_W;

  logic [SW-1:0] sidx, didx;

  assign sidx = SW'(qy) * SW'(sw) + SW'(qx);
  assign didx = SW'(row) * SW'(tw) + SW'(col);

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      in_range <= inr;
      if (inr) begin
        src_col   <= CW'(qx);
        src_row   <= CW'(qy);
        src_index <= sidx[IW-1:0];
        dst_index <= didx[IW-1:0];
      end else begin
        src_col   <= '0;
        src_row   <= '0;
        src_index <= '0;
        dst_index <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/nearest_neighbor_scale_addr_core.sv
// channel   | direction | request contents
// ----------+-----------+-------------------------------------------------------
// s_axis    | in        | tdata: dest_col, dest_row
// m_axis    | out       | tdata: src_col, src_row, src_index, dst_index; tuser: in_range
// cfg       | in        | cfg_index selects register 0..3, cfg_data is the value
//
// One request per cycle sustained while m_axis_tready stays high. The pipe is a front
// stage, a row of divider cells (one quotient bit per axis each) and an output stage.
// Every stage holds its own request while the one after it is full, so bubbles
// close up under backpressure. Reset (rst, synchronous) empties the pipe and
// sets all four dimensions to 1. cfg_ready is always high.
`default_nettype none

module nearest_neighbor_scale_addr_core #(
  parameter int MAX_DIM = nnsa_pkg::MAX_DIM_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [nnsa_pkg::S_DATA_W-1:0]  s_axis_tdata,  // dest_col, dest_row
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output      logic [nnsa_pkg::M_DATA_W-1:0]  m_axis_tdata,  // src_col, src_row, src_index, dst_index
  output      logic                           m_axis_tuser,  // in_range
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nnsa_pkg::REG_W-1:0]     cfg_data
);

  localparam int LIM = (MAX_DIM > nnsa_pkg::REG_LIMIT) ? nnsa_pkg::REG_LIMIT : MAX_DIM;
  localparam int DW  = $clog2(LIM + 1);
  localparam int CW  = nnsa_pkg::COORD_W;
  localparam int NW  = CW + DW;
  localparam int RW  = nnsa_pkg::REG_W;
  localparam int IW  = nnsa_pkg::INDEX_W;

  logic [DW-1:0] sw, sh, tw, th;

  function automatic logic [DW-1:0] clamp_dim(input logic [RW-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (v > RW'(LIM)) begin
      r = DW'(LIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= DW'(1);
      sh <= DW'(1);
      tw <= DW'(1);
      th <= DW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        nnsa_pkg::REG_SOURCE_WIDTH:  sw <= clamp_dim(cfg_data);
        nnsa_pkg::REG_SOURCE_HEIGHT: sh <= clamp_dim(cfg_data);
        nnsa_pkg::REG_TARGET_WIDTH:  tw <= clamp_dim(cfg_data);
        nnsa_pkg::REG_TARGET_HEIGHT: th <= clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  logic          vld_s [0:DW];
  logic          rdy_s [0:DW];
  logic [NW-1:0] rx_s  [0:DW];
  logic [NW-1:0] ry_s  [0:DW];
  logic [DW-1:0] qx_s  [0:DW];
  logic [DW-1:0] qy_s  [0:DW];
  logic [CW-1:0] col_s [0:DW];
  logic [CW-1:0] row_s [0:DW];
  logic          inr_s [0:DW];

  logic [CW-1:0] src_col, src_row;
  logic [IW-1:0] src_index, dst_index;

  assign qx_s[0] = '0;
  assign qy_s[0] = '0;

  nnsa_front #(.DW(DW), .NW(NW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s_axis_tvalid),
    .up_ready (s_axis_tready),
    .col_in   (s_axis_tdata[CW-1:0]),
    .row_in   (s_axis_tdata[2*CW-1:CW]),
    .sw       (sw),
    .sh       (sh),
    .tw       (tw),
    .th       (th),
    .dn_valid (vld_s[0]),
    .dn_ready (rdy_s[0]),
    .rx       (rx_s[0]),
    .ry       (ry_s[0]),
    .col      (col_s[0]),
    .row      (row_s[0]),
    .inr      (inr_s[0])
  );

  for (genvar j = 0; j < DW; j++) begin : g_cell
    nnsa_cell #(.DW(DW), .NW(NW), .K(DW - 1 - j)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld_s[j]),
      .up_ready (rdy_s[j]),
      .tw       (tw),
      .th       (th),
      .rx_in    (rx_s[j]),
      .ry_in    (ry_s[j]),
      .qx_in    (qx_s[j]),
      .qy_in    (qy_s[j]),
      .col_in   (col_s[j]),
      .row_in   (row_s[j]),
      .inr_in   (inr_s[j]),
      .dn_valid (vld_s[j+1]),
      .dn_ready (rdy_s[j+1]),
      .rx       (rx_s[j+1]),
      .ry       (ry_s[j+1]),
      .qx       (qx_s[j+1]),
      .qy       (qy_s[j+1]),
      .col      (col_s[j+1]),
      .row      (row_s[j+1]),
      .inr      (inr_s[j+1])
    );
  end

  nnsa_out #(.DW(DW)) u_out (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (vld_s[DW]),
    .up_ready  (rdy_s[DW]),
    .qx        (qx_s[DW]),
    .qy        (qy_s[DW]),
    .col       (col_s[DW]),
    .row       (row_s[DW]),
    .inr       (inr_s[DW]),
    .sw        (sw),
    .tw        (tw),
    .dn_valid  (m_axis_tvalid),
    .dn_ready  (m_axis_tready),
    .src_col   (src_col),
    .src_row   (src_row),
    .src_index (src_index),
    .dst_index (dst_index),
    .in_range  (m_axis_tuser)
  );

  assign m_axis_tdata = {dst_index, src_index, src_row, src_col};

endmodule

`default_nettype wire

// File: rtl/nnsa_checker.sv
`default_nettype none

module nnsa_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [nnsa_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input wire logic                           m_axis_tuser,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // out-of-range requests carry all-zero indices
  a_zero_oor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero payload on out-of-range result");

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result offered right after reset");

  // configuration is never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind nearest_neighbor_scale_addr_core nnsa_checker u_nnsa_checker (.*);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int COORD_W     = nnsa_pkg::COORD_W;
  localparam int REG_W       = nnsa_pkg::REG_W;
  localparam int INDEX_W     = nnsa_pkg::INDEX_W;
  localparam int CFG_IDX_W   = nnsa_pkg::CFG_IDX_W;
  localparam int S_DATA_W    = nnsa_pkg::S_DATA_W;
  localparam int M_DATA_W    = nnsa_pkg::M_DATA_W;
  localparam int MAX_DIM_DEF = nnsa_pkg::MAX_DIM_DEF;
  localparam int REG_LIMIT   = nnsa_pkg::REG_LIMIT;

  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int FIRST_BAD_REG = 4;
  localparam int REG_SLOTS     = 1 << CFG_IDX_W;
  localparam int PHASE_ITEMS   = 50;
  localparam int RANDOM_PHASES = 8;

  localparam logic [REG_W-1:0] DIM_MAX = REG_W'(MAX_DIM_DEF);
  localparam logic [REG_W-1:0] DIM_TOP = REG_W'(REG_LIMIT);

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } dest_coord_t;

  typedef struct packed {
    logic               in_range;
    logic [INDEX_W-1:0] dst_index;
    logic [INDEX_W-1:0] src_index;
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] src_col;
  } src_map_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [REG_W-1:0]    cfg_data      = '0;

  dest_coord_t pending_coords[$];
  src_map_t    expected_maps[$];
  logic [REG_W-1:0] dim_regs[REG_SLOTS];

  int coords_issued   = 0;
  int coords_accepted = 0;
  int fail_count      = 0;
  int cycle_count     = 0;
  int tx_mode = 0, tx_burst_left = 0, tx_gap_left = 0;
  int rx_mode = 0, rx_left = 0;

  nearest_neighbor_scale_addr_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // dest_col, dest_row
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // src_col, src_row, src_index, dst_index
    .m_axis_tuser  (m_axis_tuser),   // in_range
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned eff_dim(logic [REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
    return r;
  endfunction

  function automatic src_map_t map_coord(dest_coord_t c);
    longint unsigned sw, sh, tw, th, sc, sr, col, row;
    src_map_t m;
    sw  = eff_dim(dim_regs[nnsa_pkg::REG_SOURCE_WIDTH]);
    sh  = eff_dim(dim_regs[nnsa_pkg::REG_SOURCE_HEIGHT]);
    tw  = eff_dim(dim_regs[nnsa_pkg::REG_TARGET_WIDTH]);
    th  = eff_dim(dim_regs[nnsa_pkg::REG_TARGET_HEIGHT]);
    col = c.col;
    row = c.row;
    m   = '0;
    if (col < tw && row < th) begin
      sc          = (col * sw) / tw;
      sr          = (row * sh) / th;
      m.src_col   = COORD_W'(sc);
      m.src_row   = COORD_W'(sr);
      m.src_index = INDEX_W'(sr * sw + sc);
      m.dst_index = INDEX_W'(row * tw + col);
      m.in_range  = 1'b1;
    end
    return m;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // request driver: back-to-back, or bursts with gaps
  always @(posedge clk) begin
    dest_coord_t c;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        tx_gap_left--;
      end else if (pending_coords.size() != 0) begin
        c = pending_coords.pop_front();
        s_axis_tdata  <= c;
        s_axis_tvalid <= 1'b1;
        if (tx_mode != 0) begin
          if (tx_burst_left <= 1) begin
            tx_burst_left = $urandom_range(12, 1);
            tx_gap_left   = (tx_mode == 1) ? $urandom_range(4, 1) : $urandom_range(20, 1);
          end else begin
            tx_burst_left--;
          end
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_left = 0;
    end else if (rx_left != 0) begin
      rx_left--;
    end else if (rx_mode == 0) begin
      m_axis_tready <= 1'b1;
      rx_left = 8;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      rx_left = (rx_mode == 1) ? $urandom_range(3, 1) : $urandom_range(30, 1);
    end else begin
      m_axis_tready <= 1'b1;
      rx_left = (rx_mode == 1) ? $urandom_range(8, 1) : $urandom_range(20, 1);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    src_map_t exp_m, act_m;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_maps.push_back(map_coord(dest_coord_t'(s_axis_tdata)));
        coords_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act_m = {m_axis_tuser, m_axis_tdata};
        if (expected_maps.size() == 0) begin
          $error("unexpected result: tdata 0x%0h tuser %0b", m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          exp_m = expected_maps.pop_front();
          check_field("src_col", exp_m.src_col, act_m.src_col);
          check_field("src_row", exp_m.src_row, act_m.src_row);
          check_field("src_index", exp_m.src_index, act_m.src_index);
          check_field("dst_index", exp_m.dst_index, act_m.dst_index);
          check_field("in_range", exp_m.in_range, act_m.in_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= nnsa_pkg::REG_TARGET_HEIGHT) dim_regs[idx] = val;
  endtask

  task automatic write_dims(input logic [REG_W-1:0] sw, input logic [REG_W-1:0] sh,
                            input logic [REG_W-1:0] tw, input logic [REG_W-1:0] th);
    write_reg(nnsa_pkg::REG_SOURCE_WIDTH, sw);
    write_reg(nnsa_pkg::REG_SOURCE_HEIGHT, sh);
    write_reg(nnsa_pkg::REG_TARGET_WIDTH, tw);
    write_reg(nnsa_pkg::REG_TARGET_HEIGHT, th);
  endtask

  task automatic queue_coord(input int col, input int row);
    dest_coord_t c;
    c.col = COORD_W'(col);
    c.row = COORD_W'(row);
    pending_coords.push_back(c);
    coords_issued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_coords.size() != 0 || coords_accepted != coords_issued ||
           expected_maps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] pick_dim();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return REG_W'(1);
      2:       return DIM_MAX;
      3:       return REG_W'($urandom_range(REG_LIMIT, MAX_DIM_DEF + 1));
      4:       return REG_W'($urandom_range(REG_LIMIT, 0));
      5:       return REG_W'($urandom_range(16, 1));
      default: return REG_W'($urandom_range(MAX_DIM_DEF, 1));
    endcase
  endfunction

  function automatic int pick_coord(int lim);
    case ($urandom_range(9, 0))
      6, 7:    return $urandom_range(4095, 0);
      8:       return (lim > 4095) ? 4095 : lim;
      9:       return lim - 1;
      default: return $urandom_range(lim - 1, 0);
    endcase
  endfunction

  initial begin
    int tw, th;
    for (int i = 0; i < REG_SLOTS; i++) dim_regs[i] = REG_W'(1);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: 1x1 everywhere
    queue_coord(0, 0);
    queue_coord(1, 0);
    queue_coord(0, 1);
    queue_coord(4095, 4095);
    wait_drained();

    // full size both ways
    tx_mode = 1; rx_mode = 1;
    write_dims(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX);
    queue_coord(0, 0);
    queue_coord(4095, 4095);
    queue_coord(4095, 0);
    queue_coord(0, 4095);
    queue_coord(2048, 1365);
    wait_drained();

    // zero reads as one, oversize clamps to max
    tx_mode = 0; rx_mode = 2;
    write_dims(DIM_TOP, '0, '0, DIM_TOP);
    queue_coord(0, 0);
    queue_coord(0, 4095);
    queue_coord(1, 7);
    queue_coord(0, 2047);
    wait_drained();

    // upscale with edges just inside and outside the target
    tx_mode = 2; rx_mode = 0;
    write_dims(REG_W'(640), REG_W'(480), REG_W'(1920), REG_W'(1080));
    queue_coord(1919, 1079);
    queue_coord(1920, 0);
    queue_coord(0, 1080);
    queue_coord(959, 539);
    queue_coord(1, 1);
    queue_coord(3, 2);
    wait_drained();

    // writes to unused indexes must not disturb anything
    write_dims(REG_W'(1000), REG_W'(7), REG_W'(333), REG_W'(4095));
    for (int i = FIRST_BAD_REG; i < REG_SLOTS; i++)
      write_reg(CFG_IDX_W'(i), REG_W'($urandom_range(REG_LIMIT, 0)));
    queue_coord(332, 4094);
    queue_coord(333, 100);
    queue_coord(17, 6);
    queue_coord(0, 4095);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tx_mode = (p == 0) ? 0 : $urandom_range(2, 0);
      rx_mode = (p == 0) ? 0 : $urandom_range(2, 0);
      write_dims(pick_dim(), pick_dim(), pick_dim(), pick_dim());
      if ($urandom_range(3, 0) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SLOTS - 1, FIRST_BAD_REG)),
                  REG_W'($urandom_range(REG_LIMIT, 0)));
      tw = int'(eff_dim(dim_regs[nnsa_pkg::REG_TARGET_WIDTH]));
      th = int'(eff_dim(dim_regs[nnsa_pkg::REG_TARGET_HEIGHT]));
      for (int i = 0; i < PHASE_ITEMS; i++) queue_coord(pick_coord(tw), pick_coord(th));
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
